// ===== hw/rtl/afp_pkg.sv =====
// Package for the ANVL field parser: byte classes, parser states,
// destination and status codes, and the class flags passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package afp_pkg;

  typedef enum logic [2:0] {
    CLS_TEXT  = 3'd0,
    CLS_SPACE = 3'd1,
    CLS_COLON = 3'd2,
    CLS_HASH  = 3'd3,
    CLS_CR    = 3'd4,
    CLS_LF    = 3'd5,
    CLS_SEP   = 3'd6,
    CLS_CTL   = 3'd7
  } byte_class_e;

  typedef enum logic [3:0] {
    ST_KEYFIRST  = 4'd0,
    ST_ENDLF     = 4'd1,
    ST_KEY       = 4'd2,
    ST_VALUE     = 4'd3,
    ST_LF        = 4'd4,
    ST_TEXT      = 4'd5,
    ST_SPACE     = 4'd6,
    ST_COMMENT   = 4'd7,
    ST_COMMENTLF = 4'd8
  } parse_state_e;

  typedef enum logic [1:0] {
    DEST_NONE    = 2'd0,
    DEST_KEY     = 2'd1,
    DEST_VALUE   = 2'd2,
    DEST_COMMENT = 2'd3
  } byte_dest_e;

  typedef enum logic [1:0] {
    STAT_PARSING = 2'd0,
    STAT_DONE    = 2'd1,
    STAT_BLANK   = 2'd2,
    STAT_ERROR   = 2'd3
  } parse_status_e;

  // Class of a byte, plus a flag for the plain space character alone
  typedef struct packed {
    byte_class_e cls;
    logic        is_space;
  } class_info_t;

  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrColon = 8'h3A;
  localparam logic [7:0] ChrHash  = 8'h23;
  localparam logic [7:0] CtlMax   = 8'd31;
  localparam logic [7:0] ChrDel   = 8'd127;

endpackage

// ===== hw/rtl/afp_in_if.sv =====
// Input channel of the ANVL field parser: one raw header byte per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface afp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/afp_out_if.sv =====
// Result channel of the ANVL field parser: echoed byte, destination, status.
// Depends on nothing.
`timescale 1ns / 1ps

interface afp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] byte_dest;
  logic [1:0] status;

  modport source (output valid, output byte_out, output byte_dest, output status,
                  input ready);
  modport sink   (input valid, input byte_out, input byte_dest, input status,
                  output ready);
endinterface

// ===== hw/rtl/afp_classifier.sv =====
// Byte classifier: maps a raw byte to its class.
// Depends on afp_pkg.
`timescale 1ns / 1ps

module afp_classifier (
  input  logic [7:0]          data_i,
  output afp_pkg::class_info_t info_o
);
  import afp_pkg::*;

  byte_class_e cls;

  // First match wins
  always_comb begin
    if (data_i == ChrSpace || data_i == ChrTab) begin
      cls = CLS_SPACE;
    end else if (data_i == ChrColon) begin
      cls = CLS_COLON;
    end else if (data_i == ChrHash) begin
      cls = CLS_HASH;
    end else if (data_i == ChrCr) begin
      cls = CLS_CR;
    end else if (data_i == ChrLf) begin
      cls = CLS_LF;
    end else if (data_i <= CtlMax || data_i == ChrDel) begin
      cls = CLS_CTL;
    end else begin
      unique case (data_i) inside
        8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h5C,
        8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h22: cls = CLS_SEP;
        default: cls = CLS_TEXT;
      endcase
    end
  end

  assign info_o.cls      = cls;
  assign info_o.is_space = (data_i == ChrSpace);

endmodule

// ===== hw/rtl/afp_fsm.sv =====
// Parser state machine: holds the parse state and decides destination and
// status for each classified byte. Depends on afp_pkg.
`timescale 1ns / 1ps

module afp_fsm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  afp_pkg::class_info_t  info_i,
  output afp_pkg::byte_dest_e   dest_o,
  output afp_pkg::parse_status_e status_o,
  output afp_pkg::parse_state_e state_o
);
  import afp_pkg::*;

  parse_state_e  state_q, state_d, next;
  byte_dest_e    dest;
  parse_status_e status;
  byte_class_e   c;

  assign c = info_i.cls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_KEYFIRST;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    next   = ST_KEYFIRST;
    dest   = DEST_NONE;
    status = STAT_ERROR;
    unique case (state_q)
      ST_KEYFIRST: begin
        if (c == CLS_TEXT) begin
          dest = DEST_KEY; next = ST_KEY; status = STAT_PARSING;
        end else if (c == CLS_CR) begin
          next = ST_ENDLF; status = STAT_PARSING;
        end else if (c == CLS_HASH) begin
          next = ST_COMMENT; status = STAT_PARSING;
        end
      end
      ST_ENDLF: begin
        if (c == CLS_LF) status = STAT_BLANK;
      end
      ST_KEY: begin
        if (c == CLS_TEXT || c == CLS_HASH) begin
          dest = DEST_KEY; next = ST_KEY; status = STAT_PARSING;
        end else if (c == CLS_COLON) begin
          next = ST_VALUE; status = STAT_PARSING;
        end
      end
      ST_VALUE: begin
        dest = DEST_VALUE; status = STAT_PARSING;
        next = (c == CLS_CR) ? ST_LF : ST_VALUE;
      end
      ST_LF: begin
        dest = DEST_VALUE; status = STAT_PARSING;
        next = (c == CLS_LF) ? ST_SPACE : ST_VALUE;
      end
      ST_SPACE: begin
        if (c == CLS_SPACE) begin
          dest = DEST_VALUE; next = ST_TEXT; status = STAT_PARSING;
        end else if (c == CLS_TEXT || c == CLS_CR || c == CLS_LF ||
                     c == CLS_HASH || c == CLS_COLON) begin
          status = STAT_DONE;
        end
      end
      ST_TEXT: begin
        if (!info_i.is_space) begin
          dest = DEST_VALUE; next = ST_VALUE; status = STAT_PARSING;
        end
      end
      ST_COMMENT: begin
        if (c == CLS_CR) begin
          dest = DEST_COMMENT; next = ST_COMMENTLF; status = STAT_PARSING;
        end else if (c == CLS_TEXT || c == CLS_SPACE || c == CLS_COLON ||
                     c == CLS_LF || c == CLS_HASH) begin
          dest = DEST_COMMENT; next = ST_COMMENT; status = STAT_PARSING;
        end
      end
      ST_COMMENTLF: begin
        if (c == CLS_LF) begin
          dest = DEST_COMMENT; next = ST_KEYFIRST; status = STAT_PARSING;
        end else if (c == CLS_CR || c == CLS_TEXT || c == CLS_SPACE ||
                     c == CLS_COLON || c == CLS_HASH) begin
          dest = DEST_COMMENT; next = ST_COMMENT; status = STAT_PARSING;
        end
      end
      default: ;
    endcase

    // Any ending drops the destination and returns to the start
    if (status != STAT_PARSING) begin
      next = ST_KEYFIRST;
      dest = DEST_NONE;
    end

    state_d = step_i ? next : state_q;
  end

  assign dest_o   = dest;
  assign status_o = status;
  assign state_o  = state_q;

endmodule

// ===== hw/rtl/anvl_field_parser_core.sv =====
// ANVL field parser top level: input register, classifier, state machine and
// result register. Depends on afp_pkg, afp_in_if, afp_out_if, afp_classifier, afp_fsm.
`timescale 1ns / 1ps

// Takes one header byte per word and returns one result word per byte: the
// byte echoed, where it belongs (none, key, value, comment) and the outcome
// (parsing, field done with the byte handed back, blank line, error). The
// block sustains one byte per clock cycle while the result side is not
// stalled. An accepted byte waits in the input register, is parsed and is
// loaded into the result register, from which its result word is offered.
// These are the two pipeline registers, input then result; the parse-state
// register advances once per byte in step with the load of the result
// register and is not a further pipeline register.
// A stalled result side holds both registers; input stays ready while the
// input register is empty or moving on.
module anvl_field_parser_core (
  input  logic clk_i,
  input  logic rst_ni,
  afp_in_if.sink    in_i,
  afp_out_if.source out_o
);
  import afp_pkg::*;

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Result register
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  byte_dest_e    out_dest_q;
  parse_status_e out_status_q;

  logic          advance;   // result register free to load
  logic          step;      // a byte moves into the result register
  class_info_t   info;
  byte_dest_e    dest;
  parse_status_e status;
  parse_state_e  state;

  assign advance  = !out_valid_q || out_o.ready;
  assign step     = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // Payload: load on every accepted word, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
    end
  end

  afp_classifier u_classifier (
    .data_i (in_byte_q),
    .info_o (info)
  );

  afp_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .info_i   (info),
    .dest_o   (dest),
    .status_o (status),
    .state_o  (state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q   <= in_byte_q;
      out_dest_q   <= dest;
      out_status_q <= status;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.byte_out  = out_byte_q;
  assign out_o.byte_dest = out_dest_q;
  assign out_o.status    = out_status_q;

`ifndef SYNTHESIS
  // An ending always carries no destination
  a_end_no_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != STAT_PARSING |-> out_dest_q == DEST_NONE)
    else $error("ending result carries a destination");

  // After an ending the parser is back at the start state
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && status != STAT_PARSING |=> state == ST_KEYFIRST)
    else $error("parser did not return to start after an ending");

  // State moves only when a byte is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(state))
    else $error("parse state changed without a byte");

  // An empty result register never blocks the input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with an empty result register");
`endif

endmodule

// ===== bench/tb_anvl_field_parser_core.sv =====
// Testbench for anvl_field_parser_core: drives raw header bytes through the
// input channel and checks every result word against a byte-serial predictor.
// Depends on afp_pkg, afp_in_if, afp_out_if and the parser RTL.
`timescale 1ns / 1ps

module tb_anvl_field_parser_core;
  import afp_pkg::*;

  // One expected result word: echoed byte, destination tag and outcome
  typedef struct packed {
    logic [7:0]    data;
    byte_dest_e    dest;
    parse_status_e status;
  } byte_tag_t;

  // Holds its own parse state, predicts the tag of every accepted byte and
  // checks result words in arrival order.
  class anvl_tag_checker;
    parse_state_e state;
    byte_tag_t    expected_tags[$];
    int           n_errors;
    int           n_results;

    function new();
      state     = ST_KEYFIRST;
      n_errors  = 0;
      n_results = 0;
    endfunction

    // First match wins: space/tab, colon, hash, CR, LF, control, separator
    static function byte_class_e classify(logic [7:0] b);
      if (b == ChrSpace || b == ChrTab) return CLS_SPACE;
      if (b == ChrColon) return CLS_COLON;
      if (b == ChrHash) return CLS_HASH;
      if (b == ChrCr) return CLS_CR;
      if (b == ChrLf) return CLS_LF;
      if (b <= CtlMax || b == ChrDel) return CLS_CTL;
      case (b)
        // ( ) < > @ , ; \ / [ ] ? = { } "
        8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h5C,
        8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h22: return CLS_SEP;
        default: return CLS_TEXT;
      endcase
    endfunction

    function byte_tag_t parse_byte(logic [7:0] b);
      byte_class_e   c;
      parse_state_e  nxt;
      byte_dest_e    d;
      parse_status_e s;
      c   = classify(b);
      nxt = ST_KEYFIRST;
      d   = DEST_NONE;
      s   = STAT_ERROR;
      case (state)
        ST_KEYFIRST: begin
          if (c == CLS_TEXT) begin
            d = DEST_KEY; nxt = ST_KEY; s = STAT_PARSING;
          end else if (c == CLS_CR) begin
            nxt = ST_ENDLF; s = STAT_PARSING;
          end else if (c == CLS_HASH) begin
            nxt = ST_COMMENT; s = STAT_PARSING;
          end
        end
        ST_ENDLF: begin
          if (c == CLS_LF) s = STAT_BLANK;
        end
        ST_KEY: begin
          if (c == CLS_TEXT || c == CLS_HASH) begin
            d = DEST_KEY; nxt = ST_KEY; s = STAT_PARSING;
          end else if (c == CLS_COLON) begin
            nxt = ST_VALUE; s = STAT_PARSING;
          end
        end
        ST_VALUE: begin
          d = DEST_VALUE; s = STAT_PARSING;
          nxt = (c == CLS_CR) ? ST_LF : ST_VALUE;
        end
        ST_LF: begin
          d = DEST_VALUE; s = STAT_PARSING;
          nxt = (c == CLS_LF) ? ST_SPACE : ST_VALUE;
        end
        ST_SPACE: begin
          if (c == CLS_SPACE) begin
            d = DEST_VALUE; nxt = ST_TEXT; s = STAT_PARSING;
          end else if (c == CLS_TEXT || c == CLS_CR || c == CLS_LF ||
                       c == CLS_HASH || c == CLS_COLON) begin
            s = STAT_DONE;
          end
        end
        ST_TEXT: begin
          if (b != ChrSpace) begin
            d = DEST_VALUE; nxt = ST_VALUE; s = STAT_PARSING;
          end
        end
        ST_COMMENT: begin
          if (c == CLS_CR) begin
            d = DEST_COMMENT; nxt = ST_COMMENTLF; s = STAT_PARSING;
          end else if (c == CLS_TEXT || c == CLS_SPACE || c == CLS_COLON ||
                       c == CLS_LF || c == CLS_HASH) begin
            d = DEST_COMMENT; nxt = ST_COMMENT; s = STAT_PARSING;
          end
        end
        ST_COMMENTLF: begin
          if (c == CLS_LF) begin
            d = DEST_COMMENT; nxt = ST_KEYFIRST; s = STAT_PARSING;
          end else if (c == CLS_CR || c == CLS_TEXT || c == CLS_SPACE ||
                       c == CLS_COLON || c == CLS_HASH) begin
            d = DEST_COMMENT; nxt = ST_COMMENT; s = STAT_PARSING;
          end
        end
        default: ;
      endcase
      if (s != STAT_PARSING) begin
        nxt = ST_KEYFIRST;
        d   = DEST_NONE;
      end
      state = nxt;
      parse_byte = '{data: b, dest: d, status: s};
    endfunction

    function void note_byte(logic [7:0] b);
      expected_tags.push_back(parse_byte(b));
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      n_errors++;
    endtask

    task check_tag(logic [7:0] b, logic [1:0] d, logic [1:0] s);
      byte_tag_t e;
      n_results++;
      if (expected_tags.size() == 0) begin
        report($sformatf("result %0d (byte %02h) with nothing expected", n_results, b));
      end else begin
        e = expected_tags.pop_front();
        if (b !== e.data || d !== e.dest || s !== e.status)
          report($sformatf("result %0d: got byte %02h dest %0d status %0d, want %02h %0d %0d",
                           n_results, b, d, s, e.data, e.dest, e.status));
      end
    endtask

    function int pending();
      return expected_tags.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  afp_in_if  in_if ();
  afp_out_if out_if ();

  anvl_field_parser_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  anvl_tag_checker chk;
  logic [7:0]      byte_stream[$];
  int              n_sent = 0;
  int              hold_at = 32'h7fff_ffff;
  int              in_idle_pct = 0;
  int              out_idle_pct = 0;
  logic            hold_off = 1'b0;

  always #5 clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  task automatic put(logic [7:0] b);
    byte_stream.push_back(b);
  endtask

  // Draw a random byte of the given class; single-byte classes are direct
  function automatic logic [7:0] pick_of(byte_class_e c);
    logic [7:0] b;
    case (c)
      CLS_SPACE: return ($urandom_range(0, 1) != 0) ? ChrSpace : ChrTab;
      CLS_COLON: return ChrColon;
      CLS_HASH:  return ChrHash;
      CLS_CR:    return ChrCr;
      CLS_LF:    return ChrLf;
      default: begin
        do b = 8'($urandom_range(0, 255));
        while (anvl_tag_checker::classify(b) != c);
        return b;
      end
    endcase
  endfunction

  // Value bytes of any class; a CR is followed by text so that the value
  // carries on rather than turning into a line break.
  task automatic add_value(int n);
    byte_class_e c;
    repeat (n) begin
      c = byte_class_e'($urandom_range(0, 7));
      if (c == CLS_CR) begin
        put(ChrCr);
        put(pick_of(CLS_TEXT));
      end else begin
        put(pick_of(c));
      end
    end
  endtask

  // One record: mostly a well-formed field with random content, sometimes
  // a comment or blank line in front, sometimes broken or plain noise.
  task automatic add_record();
    logic [7:0]  b;
    byte_class_e c;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 7) == 0) begin
      put(ChrHash);
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 4))
          0: put(pick_of(CLS_SPACE));
          1: put(ChrColon);
          2: put(ChrHash);
          3: begin
            // lone CR inside a comment drops back into the comment
            put(ChrCr);
            put(pick_of(CLS_TEXT));
          end
          default: put(pick_of(CLS_TEXT));
        endcase
      end
      put(ChrCr);
      put(ChrLf);
    end
    if ($urandom_range(0, 11) == 0) begin
      put(ChrCr);
      put(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : ChrLf);
      return;
    end
    // key, with an occasional stray byte that usually breaks it
    put(pick_of(CLS_TEXT));
    repeat ($urandom_range(0, 7))
      put(($urandom_range(0, 4) == 0) ? ChrHash : pick_of(CLS_TEXT));
    if ($urandom_range(0, 19) == 0) put(8'($urandom_range(0, 255)));
    put(ChrColon);
    add_value($urandom_range(0, 10));
    // continuation lines: CR LF, then space or tab, then any byte
    repeat ($urandom_range(0, 2)) begin
      put(ChrCr);
      put(ChrLf);
      put(pick_of(CLS_SPACE));
      if ($urandom_range(0, 19) == 0) begin
        put(ChrSpace);
      end else begin
        do b = 8'($urandom_range(0, 255));
        while (b == ChrSpace);
        put(b);
      end
      add_value($urandom_range(0, 4));
    end
    put(ChrCr);
    put(ChrLf);
    // byte that ends the field: handed back, or an error
    case ($urandom_range(0, 11))
      0: c = CLS_SEP;
      1: c = CLS_CTL;
      2: c = CLS_CR;
      3: c = CLS_LF;
      4: c = CLS_HASH;
      5: c = CLS_COLON;
      default: c = CLS_TEXT;
    endcase
    put(pick_of(c));
  endtask

  task automatic add_directed();
    // comment line: the opening hash is untagged, the rest is comment
    put(ChrHash); put(8'h63); put(ChrCr); put(ChrLf);
    // blank line
    put(ChrCr); put(ChrLf);
    // separator where a key should start
    put(8'h28);
    // key holding a hash, then the colon
    put(8'h6B); put(ChrHash); put(ChrColon);
    // value with both byte extremes
    put(8'hFF); put(8'h00);
    // continuation: tab straight after the leading space goes into the value
    put(ChrCr); put(ChrLf); put(ChrSpace); put(ChrTab);
    // field done, byte handed back
    put(ChrCr); put(ChrLf); put(8'h58);
    // plain space after the continuation space is an error
    put(8'h6B); put(ChrColon); put(ChrCr); put(ChrLf); put(ChrSpace); put(ChrSpace);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a forced hold-off while the sender keeps going
  // ---------------------------------------------------------------------------

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_if.ready <= 1'b0;
      else          out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Hold the result side off for a long stretch so the block fills and
  // stalls its input
  initial begin
    wait (n_sent >= hold_at);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: note accepted bytes, then check any result word at the same edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) chk.note_byte(in_if.data_byte);
      if (out_if.valid && out_if.ready)
        chk.check_tag(out_if.byte_out, out_if.byte_dest, out_if.status);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int n_total;
    int idx;
    chk = new();
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    rst_n           <= 1'b0;

    add_directed();
    while (byte_stream.size() < 1000) add_record();
    n_total = byte_stream.size();
    hold_at = (2 * n_total) / 3 + 10;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (idx = 0; idx < n_total; idx++) begin
      // three phases: receiver idles more, then sender idles more, then none
      if (idx < n_total / 3) begin
        in_idle_pct  = 33;
        out_idle_pct <= 64;
      end else if (idx < (2 * n_total) / 3) begin
        in_idle_pct  = 64;
        out_idle_pct <= 33;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct <= 0;
      end
      while ($urandom_range(0, 99) < in_idle_pct) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
      in_if.valid     <= 1'b1;
      in_if.data_byte <= byte_stream[idx];
      do @(posedge clk);
      while (!in_if.ready);
      n_sent++;
    end
    in_if.valid <= 1'b0;

    // drain, then allow for any stray words
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (chk.n_errors == 0 && chk.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
